### rtl/core/morse_code_keyer_macros.svh
// Assertion macros used by the keyer RTL.
`ifndef MORSE_CODE_KEYER_MACROS_SVH
`define MORSE_CODE_KEYER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define MCK_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define MCK_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/mck_pkg.sv
// Types, constants and the code table of the Morse keyer.
`timescale 1ns / 1ps

package mck_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int QSUM_W      = QCNT_W + 1;

  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DIT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAH    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LETTER = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EOT    = 3'd4;

  localparam logic [1:0] OP_TICK   = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUIET  = 2'd2;
  localparam logic [1:0] OP_CLEAR  = 2'd3;

  localparam logic [1:0] PAUSE_NONE = 2'd0;
  localparam logic [1:0] PAUSE_WORD = 2'd1;
  localparam logic [1:0] PAUSE_EOT  = 2'd2;

  localparam logic [7:0] CHAR_ETX   = 8'h03;
  localparam logic [7:0] CHAR_EOT   = 8'h04;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] ETX_BITS   = 8'b01010101;
  localparam logic [3:0] ETX_LEN    = 4'd8;
  localparam logic [3:0] DIGIT_LEN  = 4'd5;

  localparam logic [3:0] LETTER_LEN [26] = '{
    4'd2, 4'd4, 4'd4, 4'd3, 4'd1, 4'd4, 4'd3, 4'd4, 4'd2, 4'd4, 4'd3, 4'd4, 4'd2,
    4'd2, 4'd3, 4'd4, 4'd4, 4'd3, 4'd3, 4'd1, 4'd3, 4'd4, 4'd3, 4'd4, 4'd4, 4'd4};
  localparam logic [3:0] LETTER_BITS [26] = '{
    4'h1, 4'h8, 4'hA, 4'h4, 4'h0, 4'h2, 4'h6, 4'h0, 4'h0, 4'h7, 4'h5, 4'h4, 4'h3,
    4'h2, 4'h7, 4'h6, 4'hD, 4'h2, 4'h0, 4'h1, 4'h1, 4'h1, 4'h3, 4'h9, 4'hB, 4'hC};
  localparam logic [4:0] DIGIT_BITS [10] = '{
    5'b11111, 5'h0F, 5'h07, 5'h03, 5'h01, 5'h00, 5'h10, 5'h18, 5'h1C, 5'h1E};

  typedef struct packed {
    logic [7:0] dit_ticks;
    logic [7:0] dah_ticks;
    logic [7:0] letter_pause_ticks;
    logic [7:0] word_pause_ticks;
    logic [7:0] end_pause_ticks;
  } cfg_t;

  typedef struct packed {
    logic [3:0] len;
    logic [7:0] bits;
    logic [1:0] pause;
  } sign_t;

  // A length of zero marks a pause sign; the pattern is read MSB first, 1 is a dah.
  function automatic sign_t lookup_sign(input logic [7:0] ch);
    logic [7:0] up;
    sign_t      s;
    s.len   = 4'd0;
    s.bits  = 8'd0;
    s.pause = PAUSE_NONE;
    up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
    if (up >= 8'h41 && up <= 8'h5A) begin
      s.len  = LETTER_LEN[5'(up - 8'h41)];
      s.bits = {4'd0, LETTER_BITS[5'(up - 8'h41)]};
    end else if (up >= 8'h30 && up <= 8'h39) begin
      s.len  = DIGIT_LEN;
      s.bits = {3'd0, DIGIT_BITS[4'(up - 8'h30)]};
    end else if (up == CHAR_ETX) begin
      s.len  = ETX_LEN;
      s.bits = ETX_BITS;
    end else if (up == CHAR_EOT) begin
      s.pause = PAUSE_EOT;
    end else if (up == CHAR_SPACE) begin
      s.pause = PAUSE_WORD;
    end
    return s;
  endfunction

endpackage

### rtl/core/mck_if.sv
// Command and result channel interfaces of the Morse keyer.
`timescale 1ns / 1ps

interface mck_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  char_code;
  logic [15:0] quiet_ticks;

  modport source (output valid, output operation, output char_code, output quiet_ticks,
                  input ready);
  modport sink (input valid, input operation, input char_code, input quiet_ticks,
                output ready);
endinterface

interface mck_res_if;
  logic valid;
  logic ready;
  logic busy_res;
  logic key_on;
  logic dropped;

  modport source (output valid, output busy_res, output key_on, output dropped,
                  input ready);
  modport sink (input valid, input busy_res, input key_on, input dropped,
                output ready);
endinterface

### rtl/core/morse_code_keyer.sv
// Top level of the tick-driven Morse keyer with its character queue.
`timescale 1ns / 1ps
`include "morse_code_keyer_macros.svh"

// The keyer takes one command beat per clock and returns exactly one result
// beat for it, held in an output register and shown from the cycle after the
// command is taken; a command is taken whenever that register is empty or is
// being emptied in the same cycle, so the block runs at one beat per clock as
// long as the result side keeps up. All the work of a command, the tick counter
// step, the read of the head character and its code lookup, is done in that
// same cycle. The sixteen-entry text queue sits in flip-flops and needs no
// clearing after reset. Timing registers may be written at any idle moment.

module morse_code_keyer (
  input  logic                          clk,
  input  logic                          rst,
  mck_cmd_if.sink                       cmd,
  mck_res_if.source                     res,
  input  logic                          wr_en,
  input  logic [mck_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                    wr_data
);
  import mck_pkg::*;

  cfg_t cfg;

  mck_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  logic [7:0]        queue [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head, head_next;
  logic [QCNT_W-1:0] count, count_next;
  logic [15:0]       ticks, ticks_next;
  logic [3:0]        elem, elem_next;
  logic              keying, keying_next;

  logic              accept;
  logic              busy, drop;
  logic              q_full, q_write;
  logic [QSUM_W-1:0] wsum;
  logic [QIDX_W-1:0] waddr;
  logic [QIDX_W-1:0] head_inc;
  logic [15:0]       ticks_dec;
  sign_t             sign;
  logic [7:0]        pause_nom;
  logic signed [9:0] pause_t;
  logic [15:0]       pause_len;
  logic [3:0]        shift;
  logic              elem_done;

  assign cmd.ready = !res.valid || res.ready;
  assign accept    = cmd.valid && cmd.ready;

  assign q_full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_write = accept && (cmd.operation == OP_APPEND) && !q_full;

  always_comb begin
    wsum = QSUM_W'(head) + QSUM_W'(count);
    if (wsum >= QSUM_W'(QUEUE_DEPTH)) begin
      wsum = wsum - QSUM_W'(QUEUE_DEPTH);
    end
  end
  assign waddr    = wsum[QIDX_W-1:0];
  assign head_inc = (head == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head + QIDX_W'(1);

  assign ticks_dec = (ticks != 16'd0) ? ticks - 16'd1 : 16'd0;
  assign sign      = lookup_sign(queue[head]);

  always_comb begin
    unique case (sign.pause)
      PAUSE_WORD: pause_nom = cfg.word_pause_ticks;
      PAUSE_EOT:  pause_nom = cfg.end_pause_ticks;
      default:    pause_nom = 8'd0;
    endcase
  end

  assign pause_t   = $signed({2'b00, pause_nom}) - $signed({2'b00, cfg.letter_pause_ticks})
                   + $signed({2'b00, cfg.dit_ticks});
  assign pause_len = pause_t[9] ? 16'd0 : {7'd0, pause_t[8:0]};
  assign elem_done = (sign.len == 4'd0) || (elem >= sign.len);
  assign shift     = sign.len - elem - 4'd1;

  always_comb begin
    head_next   = head;
    count_next  = count;
    ticks_next  = ticks;
    elem_next   = elem;
    keying_next = keying;
    busy        = 1'b0;
    drop        = 1'b0;
    unique case (cmd.operation)
      OP_TICK: begin
        ticks_next = ticks_dec;
        if (ticks_dec != 16'd0) begin
          busy = 1'b1;
        end else if (count != '0) begin
          busy = 1'b1;
          if (keying) begin
            keying_next = 1'b0;
            ticks_next  = {8'd0, cfg.dit_ticks};
          end else if (elem_done) begin
            ticks_next  = (sign.len == 4'd0) ? pause_len : {8'd0, cfg.letter_pause_ticks};
            keying_next = 1'b0;
            head_next   = head_inc;
            count_next  = count - QCNT_W'(1);
            elem_next   = 4'd0;
          end else begin
            keying_next = 1'b1;
            ticks_next  = sign.bits[shift[2:0]] ? {8'd0, cfg.dah_ticks}
                                                : {8'd0, cfg.dit_ticks};
            elem_next   = elem + 4'd1;
          end
        end
      end
      OP_APPEND: begin
        if (q_full) begin
          drop = 1'b1;
        end else begin
          count_next = count + QCNT_W'(1);
        end
        busy = (ticks_next != 16'd0) || (count_next != '0);
      end
      OP_QUIET: begin
        keying_next = 1'b0;
        ticks_next  = cmd.quiet_ticks;
        busy        = (ticks_next != 16'd0) || (count_next != '0);
      end
      OP_CLEAR: begin
        head_next   = '0;
        count_next  = '0;
        ticks_next  = 16'd0;
        elem_next   = 4'd0;
        keying_next = 1'b0;
        busy        = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (q_write) begin
      queue[waddr] <= cmd.char_code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      count     <= '0;
      ticks     <= 16'd0;
      elem      <= 4'd0;
      keying    <= 1'b0;
      res.valid <= 1'b0;
    end else begin
      if (accept) begin
        head   <= head_next;
        count  <= count_next;
        ticks  <= ticks_next;
        elem   <= elem_next;
        keying <= keying_next;
      end
      if (accept) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res.busy_res <= busy;
      res.key_on   <= keying_next;
      res.dropped  <= drop;
    end
  end

  `MCK_ASSERT_IMP(a_count_bound, 1'b1, count <= QCNT_W'(QUEUE_DEPTH), "queue count above depth")
  `MCK_ASSERT_IMP(a_key_needs_text, keying, count != '0, "keying with an empty queue")
  `MCK_ASSERT_IMP(a_elem_bound, 1'b1, elem <= ETX_LEN, "element index beyond longest code")
  `MCK_ASSERT_NXT(a_drop_full, accept && drop, res.valid && res.dropped, "full append not flagged")

endmodule

### rtl/core/mck_cfg_regs.sv
// Timing register file of the Morse keyer.
`timescale 1ns / 1ps

module mck_cfg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic [mck_pkg::CFG_IDX_W-1:0] wr_index,
  input  logic [7:0]                    wr_data,
  output mck_pkg::cfg_t                 cfg
);
  import mck_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dit_ticks          <= 8'd1;
      cfg.dah_ticks          <= 8'd3;
      cfg.letter_pause_ticks <= 8'd3;
      cfg.word_pause_ticks   <= 8'd7;
      cfg.end_pause_ticks    <= 8'd14;
    end else if (wr_en) begin
      case (wr_index)
        REG_DIT:    cfg.dit_ticks          <= wr_data;
        REG_DAH:    cfg.dah_ticks          <= wr_data;
        REG_LETTER: cfg.letter_pause_ticks <= wr_data;
        REG_WORD:   cfg.word_pause_ticks   <= wr_data;
        REG_EOT:    cfg.end_pause_ticks    <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

### verif/morse_code_keyer_test.sv
// Self-checking testbench for the Morse keyer: directed and random command streams.
`timescale 1ns / 1ps

module morse_code_keyer_test;
  import mck_pkg::*;

  localparam int ITEM_TARGET = 1650;
  localparam cfg_t RESET_TIMING = '{8'd1, 8'd3, 8'd3, 8'd7, 8'd14};

  typedef struct packed {
    logic busy_res;
    logic key_on;
    logic dropped;
  } keyer_out_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 wr_en = 1'b0;
  logic [CFG_IDX_W-1:0] wr_index = '0;
  logic [7:0]           wr_data = '0;

  mck_cmd_if cmd ();
  mck_res_if res ();

  morse_code_keyer u_top (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .res(res),
    .wr_en(wr_en),
    .wr_index(wr_index),
    .wr_data(wr_data)
  );

  always #2 clk = ~clk;

  logic [7:0]        text_mem [QUEUE_DEPTH];
  logic [QIDX_W-1:0] head_ptr = '0;
  logic [QCNT_W-1:0] char_count = '0;
  logic [15:0]       ticks_left = '0;
  logic [3:0]        elem_pos = '0;
  logic              key_state = 1'b0;
  cfg_t              timing = RESET_TIMING;

  keyer_out_t expected_beats [$];
  int fail_count = 0;
  int beats_sent = 0;
  int beats_checked = 0;
  int signs_played = 0;
  int drops_seen = 0;
  int hold_request = 0;
  bit rx_stalls = 1'b0;
  bit tx_gaps = 1'b0;
  int tx_burst = 0;

  function automatic string morse_pattern(input logic [7:0] ch);
    logic [7:0] up;
    up = (ch >= 8'h61 && ch <= 8'h7A) ? ch - 8'd32 : ch;
    case (up)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      CHAR_ETX: return ".-.-.-.-";
      default: return "";
    endcase
  endfunction

  task automatic advance_keyer(input logic [1:0] op, input logic [7:0] ch,
                               input logic [15:0] quiet, output keyer_out_t outp);
    string      pat;
    int         nominal;
    int         corrected;
    logic [7:0] head_ch;
    outp = '0;
    case (op)
      OP_TICK: begin
        if (ticks_left != 0) ticks_left--;
        if (ticks_left != 0) begin
          outp.busy_res = 1'b1;
        end else if (char_count != 0) begin
          outp.busy_res = 1'b1;
          if (key_state) begin
            key_state = 1'b0;
            ticks_left = 16'(timing.dit_ticks);
          end else begin
            head_ch = text_mem[head_ptr];
            pat = morse_pattern(head_ch);
            if (pat.len() == 0 || elem_pos >= pat.len()) begin
              if (pat.len() == 0) begin
                nominal = (head_ch == CHAR_EOT) ? int'(timing.end_pause_ticks) :
                          (head_ch == CHAR_SPACE) ? int'(timing.word_pause_ticks) : 0;
                corrected = nominal - (int'(timing.letter_pause_ticks) -
                                       int'(timing.dit_ticks));
                ticks_left = (corrected < 0) ? 16'd0 : 16'(corrected);
              end else begin
                ticks_left = 16'(timing.letter_pause_ticks);
              end
              key_state = 1'b0;
              head_ptr++;
              char_count--;
              elem_pos = '0;
              signs_played++;
            end else begin
              key_state = 1'b1;
              ticks_left = (pat[elem_pos] == "-") ? 16'(timing.dah_ticks) :
                                                    16'(timing.dit_ticks);
              elem_pos++;
            end
          end
        end
      end
      OP_APPEND: begin
        if (char_count >= QUEUE_DEPTH) begin
          outp.dropped = 1'b1;
        end else begin
          text_mem[QIDX_W'(head_ptr + char_count)] = ch;
          char_count++;
        end
      end
      OP_QUIET: begin
        key_state = 1'b0;
        ticks_left = quiet;
      end
      OP_CLEAR: begin
        head_ptr = '0;
        char_count = '0;
        ticks_left = '0;
        elem_pos = '0;
        key_state = 1'b0;
      end
      default: ;
    endcase
    if (op != OP_TICK) outp.busy_res = (ticks_left != 0) || (char_count != 0);
    outp.key_on = key_state;
  endtask

  task automatic send_command(input logic [1:0] op, input logic [7:0] ch,
                              input logic [15:0] quiet);
    keyer_out_t want;
    if (tx_gaps) begin
      if (tx_burst == 0) begin
        cmd.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        tx_burst = $urandom_range(1, 24);
      end
      tx_burst--;
    end
    cmd.valid <= 1'b1;
    cmd.operation <= op;
    cmd.char_code <= ch;
    cmd.quiet_ticks <= quiet;
    do @(posedge clk); while (!cmd.ready);
    advance_keyer(op, ch, quiet, want);
    expected_beats.push_back(want);
    beats_sent++;
  endtask

  task automatic wait_results_drained();
    cmd.valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic set_timing(input cfg_t c);
    wr_en <= 1'b1;
    wr_index <= REG_DIT;
    wr_data <= c.dit_ticks;
    @(posedge clk);
    wr_index <= REG_DAH;
    wr_data <= c.dah_ticks;
    @(posedge clk);
    wr_index <= REG_LETTER;
    wr_data <= c.letter_pause_ticks;
    @(posedge clk);
    wr_index <= REG_WORD;
    wr_data <= c.word_pause_ticks;
    @(posedge clk);
    wr_index <= REG_EOT;
    wr_data <= c.end_pause_ticks;
    @(posedge clk);
    wr_en <= 1'b0;
    timing = c;
  endtask

  task automatic send_tick();
    send_command(OP_TICK, 8'($urandom), 16'($urandom));
  endtask

  task automatic play_out(input int extra);
    int guard;
    guard = 0;
    while ((ticks_left != 0 || char_count != 0) && guard < 4000) begin
      send_tick();
      guard++;
    end
    repeat (extra) send_tick();
  endtask

  function automatic logic [7:0] random_char();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) return 8'h41 + 8'($urandom_range(0, 25));
    else if (pick < 60) return 8'h61 + 8'($urandom_range(0, 25));
    else if (pick < 75) return 8'h30 + 8'($urandom_range(0, 9));
    else if (pick < 83) return CHAR_SPACE;
    else if (pick < 87) return CHAR_EOT;
    else if (pick < 90) return CHAR_ETX;
    else if (pick < 94) return 8'($urandom_range(5, 9));
    else return 8'($urandom);
  endfunction

  initial begin
    int  run_left;
    bit  level;
    run_left = 0;
    level = 1'b1;
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        res.ready <= 1'b0;
        repeat (hold_request) @(posedge clk);
        hold_request = 0;
        res.ready <= 1'b1;
      end else if (rx_stalls) begin
        if (run_left == 0) begin
          level = !level;
          run_left = level ? $urandom_range(1, 10) : $urandom_range(1, 4);
        end
        run_left--;
        res.ready <= level;
      end else begin
        res.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    keyer_out_t want;
    if (!rst && res.valid && res.ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: result beat with nothing expected: busy_res %b key_on %b dropped %b",
                 $time, res.busy_res, res.key_on, res.dropped);
        fail_count++;
      end else begin
        want = expected_beats.pop_front();
        if ({res.busy_res, res.key_on, res.dropped} !== want) begin
          $display("%0t: mismatch: expected busy_res %b key_on %b dropped %b, actual %b %b %b",
                   $time, want.busy_res, want.key_on, want.dropped,
                   res.busy_res, res.key_on, res.dropped);
          fail_count++;
        end
        if (want.dropped) drops_seen++;
      end
      beats_checked++;
    end
  end

  task automatic test_idle_tick();
    send_tick();
    send_tick();
  endtask

  task automatic test_queue_fill();
    logic [7:0] fill [17];
    fill = '{"A", "z", "0", "9", CHAR_ETX, CHAR_EOT, CHAR_SPACE, 8'd5, 8'd9, 8'hFF,
             8'h00, "e", "T", "5", "Q", "y", "K"};
    foreach (fill[i]) send_command(OP_APPEND, fill[i], 16'h0000);
    repeat (4) send_tick();
    send_command(OP_QUIET, 8'hFF, 16'hFFFF);
    send_command(OP_QUIET, 8'h00, 16'h0000);
    send_command(OP_CLEAR, 8'hFF, 16'hFFFF);
    send_tick();
  endtask

  task automatic test_pause_correction();
    wait_results_drained();
    set_timing(cfg_t'{8'd1, 8'd1, 8'd255, 8'd0, 8'd255});
    send_command(OP_APPEND, CHAR_EOT, 16'd0);
    send_command(OP_APPEND, CHAR_SPACE, 16'd0);
    send_command(OP_APPEND, 8'd7, 16'd0);
    play_out(2);
  endtask

  task automatic test_wide_pause();
    wait_results_drained();
    set_timing(cfg_t'{8'd255, 8'd255, 8'd1, 8'd255, 8'd255});
    send_command(OP_APPEND, CHAR_SPACE, 16'd0);
    play_out(2);
  endtask

  task automatic test_output_hold_off();
    wait_results_drained();
    set_timing(RESET_TIMING);
    tx_gaps = 1'b0;
    hold_request = 64;
    send_command(OP_APPEND, "S", 16'd0);
    send_command(OP_APPEND, "O", 16'd0);
    send_command(OP_APPEND, "S", 16'd0);
    repeat (20) send_tick();
    wait_results_drained();
    play_out(1);
  endtask

  task automatic test_random_traffic();
    cfg_t phase_cfg;
    int   kind;
    while (beats_sent < ITEM_TARGET) begin
      case ($urandom_range(0, 3))
        0: phase_cfg = RESET_TIMING;
        1: phase_cfg = cfg_t'{8'd1, 8'd1, 8'd1, 8'd0, 8'd0};
        default: phase_cfg = cfg_t'{8'($urandom_range(1, 4)), 8'($urandom_range(1, 5)),
                                    8'($urandom_range(1, 5)), 8'($urandom_range(0, 9)),
                                    8'($urandom_range(0, 12))};
      endcase
      wait_results_drained();
      set_timing(phase_cfg);
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_stalls = ($urandom_range(0, 3) != 0);
      repeat (6) begin
        kind = $urandom_range(0, 19);
        if (kind < 14) begin
          repeat ($urandom_range(1, 4)) send_command(OP_APPEND, random_char(), 16'($urandom));
          play_out($urandom_range(0, 3));
        end else if (kind < 16) begin
          repeat ($urandom_range(1, 2)) send_command(OP_APPEND, random_char(), 16'($urandom));
          repeat ($urandom_range(1, 6)) send_tick();
          send_command(OP_QUIET, 8'($urandom), 16'($urandom_range(0, 12)));
          play_out(1);
        end else if (kind < 17) begin
          send_command(OP_QUIET, 8'($urandom), 16'($urandom));
          repeat ($urandom_range(0, 3)) send_tick();
          if ($urandom_range(0, 1) != 0)
            send_command(OP_CLEAR, 8'($urandom), 16'($urandom));
          else
            send_command(OP_QUIET, 8'($urandom), 16'($urandom_range(0, 5)));
          play_out(0);
        end else if (kind < 18) begin
          repeat (QUEUE_DEPTH + $urandom_range(1, 3))
            send_command(OP_APPEND, 8'($urandom), 16'($urandom));
          repeat ($urandom_range(0, 4)) send_tick();
          send_command(OP_CLEAR, 8'($urandom), 16'($urandom));
        end else begin
          repeat ($urandom_range(1, 3)) send_command(OP_APPEND, random_char(), 16'($urandom));
          repeat ($urandom_range(0, 8)) send_tick();
          send_command(OP_CLEAR, 8'($urandom), 16'($urandom));
          send_tick();
        end
      end
    end
  endtask

  initial begin
    int guard;
    cmd.valid = 1'b0;
    cmd.operation = OP_TICK;
    cmd.char_code = 8'd0;
    cmd.quiet_ticks = 16'd0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    tx_gaps = 1'b1;
    rx_stalls = 1'b1;
    test_idle_tick();
    test_queue_fill();
    test_pause_correction();
    test_wide_pause();
    test_output_hold_off();
    test_random_traffic();
    cmd.valid <= 1'b0;
    rx_stalls = 1'b0;
    guard = 0;
    while (expected_beats.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (4) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, expected_beats.size());
      fail_count += expected_beats.size();
    end
    $display("Sent %0d command beats and checked %0d result beats under several timings.",
             beats_sent, beats_checked);
    $display("Keyed %0d signs to completion; %0d appends were refused on a full queue.",
             signs_played, drops_seen);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("Timed out at %0t with %0d result beats outstanding.", $time,
             expected_beats.size());
    $display("Test completed with failures");
    $finish;
  end

endmodule

### morse_code_keyer.f
+incdir+rtl/core
rtl/core/mck_pkg.sv
rtl/core/mck_if.sv
rtl/core/mck_cfg_regs.sv
rtl/core/morse_code_keyer.sv
verif/morse_code_keyer_test.sv
